// ===== hdl/mtcqf_pkg.sv =====
`default_nettype none

package mtcqf_pkg;

	localparam int unsigned IDX_W = 4;

	localparam logic [3:0] PIECE_FRAME_LO  = 4'd0;
	localparam logic [3:0] PIECE_FRAME_HI  = 4'd1;
	localparam logic [3:0] PIECE_SEC_LO    = 4'd2;
	localparam logic [3:0] PIECE_SEC_HI    = 4'd3;
	localparam logic [3:0] PIECE_MIN_LO    = 4'd4;
	localparam logic [3:0] PIECE_MIN_HI    = 4'd5;
	localparam logic [3:0] PIECE_HOUR_LO   = 4'd6;
	localparam logic [3:0] PIECE_HOUR_HI   = 4'd7;

	localparam logic [7:0] BYTE_CLOCK      = 8'hF8;
	localparam logic [7:0] BYTE_SYSEX      = 8'hF0;
	localparam logic [7:0] BYTE_MFR_ID     = 8'h28;
	localparam logic [7:0] BYTE_POS_CMD    = 8'h15;
	localparam logic [7:0] BYTE_PAD        = 8'h00;
	localparam logic [7:0] BYTE_EOX        = 8'hF7;

	localparam logic [1:0] LAG_EARLY       = 2'd0;
	localparam logic [1:0] LAG_MID         = 2'd1;
	localparam logic [1:0] LAG_FULL        = 2'd2;

	localparam logic [1:0] RATE_RESET      = 2'd3;
	localparam logic [7:0] SYNC_MAX        = 8'hFF;

	localparam logic [IDX_W-1:0] IDX_LAST_SINGLE = 4'd0;
	localparam logic [IDX_W-1:0] IDX_LAST_POS    = 4'd9;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_CLOCK,
		EM_POS
	} emit_mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] last_idx;
	} status_t;

	function automatic logic [7:0] pos_byte(
		input logic [IDX_W-1:0] idx,
		input logic [4:0]       hh,
		input logic [5:0]       mm,
		input logic [5:0]       ss,
		input logic [4:0]       ff
	);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = BYTE_SYSEX;
			4'd1:    b = BYTE_MFR_ID;
			4'd2:    b = BYTE_POS_CMD;
			4'd3:    b = {3'd0, hh};
			4'd4:    b = {2'd0, mm};
			4'd5:    b = {2'd0, ss};
			4'd6:    b = {3'd0, ff};
			4'd7:    b = BYTE_PAD;
			4'd8:    b = BYTE_EOX;
			default: b = BYTE_CLOCK;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mtcqf_if.sv =====
`default_nettype none

interface mtcqf_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface mtcqf_out_if;
	logic       valid;
	logic       ready;
	logic       emit_valid;
	logic [7:0] emit_byte;
	logic       last;
	logic [4:0] hours;
	logic [5:0] minutes;
	logic [5:0] seconds;
	logic [4:0] frames;
	logic [1:0] rate_type;
	logic [1:0] lag_phase;
	logic       time_updated;

	modport source (
		output valid, output emit_valid, output emit_byte, output last,
		output hours, output minutes, output seconds, output frames,
		output rate_type, output lag_phase, output time_updated,
		input ready
	);
	modport sink (
		input valid, input emit_valid, input emit_byte, input last,
		input hours, input minutes, input seconds, input frames,
		input rate_type, input lag_phase, input time_updated,
		output ready
	);
endinterface

interface mtcqf_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mtcqf_datapath.sv =====
`default_nettype none

module mtcqf_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mtcqf_pkg::cmd_t   cmd,
	output mtcqf_pkg::status_t     status,
	input  wire logic              in_action,
	input  wire logic [7:0]        in_data_byte,
	input  wire logic              cfg_we,
	input  wire logic              cfg_data,
	output logic                   emit_valid,
	output logic [7:0]             emit_byte,
	output logic                   last,
	output logic [4:0]             hours,
	output logic [5:0]             minutes,
	output logic [5:0]             seconds,
	output logic [4:0]             frames,
	output logic [1:0]             rate_type,
	output logic [1:0]             lag_phase,
	output logic                   time_updated
);
	import mtcqf_pkg::*;

	logic [3:0] frame_lo_q, sec_lo_q, min_lo_q, hour_lo_q;
	logic       frame_hi_q;
	logic [1:0] sec_hi_q, min_hi_q;
	logic [4:0] hours_q, frames_q;
	logic [5:0] minutes_q, seconds_q;
	logic [1:0] rate_q, lag_q;
	logic [7:0] sync_count_q;
	logic       enable_q, upd_q;
	emit_mode_t mode_q;

	logic [3:0] piece;
	logic       is_data;
	logic [7:0] sync_next;
	emit_mode_t mode_next;

	assign piece   = in_data_byte[7:4];
	assign is_data = !in_action;

	always_comb begin
		sync_next = (sync_count_q == SYNC_MAX) ? SYNC_MAX : sync_count_q + 8'd1;
		mode_next = EM_NONE;
		if (is_data && piece == PIECE_SEC_HI && sync_count_q != 8'd0) begin
			mode_next = EM_CLOCK;
		end else if (is_data && piece == PIECE_HOUR_HI && enable_q) begin
			mode_next = (sync_count_q == 8'd0) ? EM_POS : EM_CLOCK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			sync_count_q <= 8'd0;
			frame_lo_q   <= 4'd0;
			frame_hi_q   <= 1'b0;
			sec_lo_q     <= 4'd0;
			sec_hi_q     <= 2'd0;
			min_lo_q     <= 4'd0;
			min_hi_q     <= 2'd0;
			hour_lo_q    <= 4'd0;
			hours_q      <= 5'd0;
			minutes_q    <= 6'd0;
			seconds_q    <= 6'd0;
			frames_q     <= 5'd0;
			rate_q       <= RATE_RESET;
			lag_q        <= LAG_EARLY;
			upd_q        <= 1'b0;
			mode_q       <= EM_NONE;
		end else begin
			if (cfg_we) begin
				enable_q     <= cfg_data;
				sync_count_q <= 8'd0;
			end
			if (cmd.load) begin
				mode_q <= mode_next;
				upd_q  <= is_data && piece == PIECE_HOUR_HI;
				if (!is_data) begin
					sync_count_q <= 8'd0;
				end else begin
					unique case (piece)
						PIECE_FRAME_LO: begin
							frame_lo_q <= in_data_byte[3:0];
							lag_q      <= LAG_EARLY;
						end
						PIECE_FRAME_HI: begin
							frame_hi_q <= in_data_byte[0];
							lag_q      <= LAG_EARLY;
						end
						PIECE_SEC_LO: begin
							sec_lo_q <= in_data_byte[3:0];
							lag_q    <= LAG_EARLY;
						end
						PIECE_SEC_HI: begin
							sec_hi_q <= in_data_byte[1:0];
							lag_q    <= LAG_MID;
						end
						PIECE_MIN_LO: begin
							min_lo_q <= in_data_byte[3:0];
							lag_q    <= LAG_MID;
						end
						PIECE_MIN_HI: begin
							min_hi_q <= in_data_byte[1:0];
							lag_q    <= LAG_MID;
						end
						PIECE_HOUR_LO: begin
							hour_lo_q <= in_data_byte[3:0];
							lag_q     <= LAG_MID;
						end
						PIECE_HOUR_HI: begin
							hours_q   <= {in_data_byte[0], hour_lo_q};
							minutes_q <= {min_hi_q, min_lo_q};
							seconds_q <= {sec_hi_q, sec_lo_q};
							frames_q  <= {frame_hi_q, frame_lo_q};
							rate_q    <= in_data_byte[2:1];
							lag_q     <= LAG_FULL;
							if (enable_q) begin
								sync_count_q <= sync_next;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	assign status.last_idx = (mode_q == EM_POS) ? IDX_LAST_POS : IDX_LAST_SINGLE;

	always_comb begin
		unique case (mode_q)
			EM_POS:   emit_byte = pos_byte(cmd.idx, hours_q, minutes_q, seconds_q, frames_q);
			EM_CLOCK: emit_byte = BYTE_CLOCK;
			default:  emit_byte = BYTE_PAD;
		endcase
	end

	assign emit_valid   = (mode_q != EM_NONE);
	assign last         = (cmd.idx == status.last_idx);
	assign hours        = hours_q;
	assign minutes      = minutes_q;
	assign seconds      = seconds_q;
	assign frames       = frames_q;
	assign rate_type    = rate_q;
	assign lag_phase    = lag_q;
	assign time_updated = upd_q;

endmodule

`default_nettype wire

// ===== hdl/mtcqf_ctrl.sv =====
`default_nettype none

module mtcqf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mtcqf_pkg::cmd_t         cmd,
	input  wire mtcqf_pkg::status_t status
);
	import mtcqf_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.load  = 1'b0;
		cmd.idx   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (idx_q == status.last_idx) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/mtc_quarter_frame_decoder.sv =====
// channel   dir  handshake         payload
// in_ch     in   valid / ready     action, data_byte
// out_ch    out  valid / ready     emit_valid, emit_byte, last, time fields, lag, update flag
// cfg       in   valid / ready     direct sync enable (always ready)
//
// one request is taken, then its results go out one per cycle while out_ch is ready
// a request gives one result, or ten for the first piece 7 in direct sync
// the byte counter of the controller walks the position message
// in_ch is ready again the cycle after the last result is taken
// reset clears the time code, sync count and enable; rate type resets to 30 non-drop
`default_nettype none

module mtc_quarter_frame_decoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtcqf_in_if.sink   in_ch,
	mtcqf_out_if.source out_ch,
	mtcqf_cfg_if.sink  cfg
);
	import mtcqf_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	mtcqf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	mtcqf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_action    (in_ch.action),
		.in_data_byte (in_ch.data_byte),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.data),
		.emit_valid   (out_ch.emit_valid),
		.emit_byte    (out_ch.emit_byte),
		.last         (out_ch.last),
		.hours        (out_ch.hours),
		.minutes      (out_ch.minutes),
		.seconds      (out_ch.seconds),
		.frames       (out_ch.frames),
		.rate_type    (out_ch.rate_type),
		.lag_phase    (out_ch.lag_phase),
		.time_updated (out_ch.time_updated)
	);

`ifndef SYNTHESIS
	a_accept_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> out_ch.valid)
		else $error("no result after accepted request");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while results pending");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.last |=> in_ch.ready)
		else $error("input not ready after last result");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.emit_valid |-> out_ch.last && out_ch.emit_byte == BYTE_PAD)
		else $error("empty result not single");
`endif

endmodule

`default_nettype wire
